### src/idr_pkg.sv
package idr_pkg;

  localparam int LINE_BLOCKS_DEF = 4;

  localparam logic [15:0] OFF_CTL   = 16'h0000;
  localparam logic [15:0] OFF_TYPE  = 16'h0004;
  localparam logic [15:0] OFF_IDENT = 16'h0008;
  localparam logic [15:0] OFF_ID2   = 16'hFFE8;
  localparam logic [15:0] BASE_GRP  = 16'h0080;
  localparam logic [15:0] BASE_SEN  = 16'h0100;
  localparam logic [15:0] BASE_CEN  = 16'h0180;
  localparam logic [15:0] BASE_PRI  = 16'h0400;
  localparam logic [15:0] BASE_TRG  = 16'h0C00;
  localparam logic [15:0] BASE_RTE  = 16'h6000;

  localparam logic [31:0] CTL_RESET   = 32'h0000_0053;
  localparam logic [31:0] CTL_PENDING = 32'h8000_0000;
  localparam logic [31:0] TYPE_RESET  = 32'h0000_0003;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_MISALIGN = 2'd2;
  localparam logic [1:0] ST_READONLY = 2'd3;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_TYPE  = 2'd1;
  localparam logic [1:0] CFG_IDENT = 2'd2;

  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_CTL   = 3'd1;
  localparam logic [2:0] K_TYPE  = 3'd2;
  localparam logic [2:0] K_IDENT = 3'd3;
  localparam logic [2:0] K_ID2   = 3'd4;
  localparam logic [2:0] K_WORD  = 3'd5;
  localparam logic [2:0] K_ROUTE = 3'd6;

  localparam logic [1:0] OP_STORE = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [47:0] access_address;
    logic [63:0] write_data;
  } in_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0]  access_status;
    logic        needs_user_exit;
  } out_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] status;
    logic [1:0] wop;
    logic       wr;
  } dec_t;

endpackage

### src/interrupt_distributor_regs.sv
// Distributor register file. Each request is one bus access (read or write flag, address,
// write data) and returns one response with read data and a status. An access has a decode
// step, which decodes the offset and issues the memory read, and an execute step, which
// modifies, writes back and loads the response register; the next request is taken in the
// cycle the response is loaded, which waits while the output is stalled. Group, enable,
// priority and trigger words share one 32-bit RAM, routing words sit in a 64-bit RAM. After
// reset a clearing pass zeroes both RAMs; no request is taken during it, configuration
// writes are taken at any time.
module interrupt_distributor_regs #(
  parameter int LINE_BLOCKS = idr_pkg::LINE_BLOCKS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  idr_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output idr_pkg::out_t  out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_data
);

  localparam int WD    = 12 * LINE_BLOCKS;
  localparam int RD    = 32 * LINE_BLOCKS;
  localparam int WA_W  = $clog2(WD);
  localparam int RA_W  = $clog2(RD);
  localparam int GRP_OFS = 0;
  localparam int ENA_OFS = LINE_BLOCKS;
  localparam int PRI_OFS = 2 * LINE_BLOCKS;
  localparam int TRG_OFS = 10 * LINE_BLOCKS;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_DEC  = 2'd2;
  localparam logic [1:0] S_EXE  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [RA_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [47:0]     base_r;
  logic [31:0]     type_r;
  logic [31:0]     ident_r;
  logic [31:0]     ctl_r, ctl_nxt;
  idr_pkg::in_t    in_r;
  idr_pkg::dec_t   dec_r, dec_nxt;
  logic [WA_W-1:0] dec_wa_r, dec_wa_nxt;
  logic [RA_W-1:0] dec_ra_r, dec_ra_nxt;
  logic            out_valid_r, out_valid_nxt;
  idr_pkg::out_t   out_r, out_nxt;

  logic            in_acc, exe_done;
  logic [47:0]     off;
  logic [15:0]     lo;
  logic            in_low;
  logic [5:0]      blk_raw, blk;
  logic [15:0]     blk16;
  logic [15:0]     rel_grp, rel_sen, rel_cen, rel_pri, rel_trg, rel_rte;
  logic            hit_grp, hit_sen, hit_cen, hit_pri, hit_trg, hit_rte;

  logic            wram_we, wram_re, rram_we, rram_re;
  logic [WA_W-1:0] wram_waddr;
  logic [31:0]     wram_wdata, wram_q;
  logic [RA_W-1:0] rram_waddr;
  logic [63:0]     rram_wdata, rram_q;
  logic            exe_wwe, exe_rwe;
  logic [31:0]     exe_wdata;
  logic [63:0]     exe_rd;

  assign cfg_ready = 1'b1;
  assign exe_done  = (state_r == S_EXE) && (!out_valid_r || !out_stall);
  assign in_stall  = !((state_r == S_IDLE) || exe_done);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // offset decode
  always_comb begin
    off     = in_r.access_address - base_r;
    lo      = off[15:0];
    in_low  = (off[47:16] == 32'd0);
    blk_raw = {1'b0, type_r[4:0]} + 6'd1;
    blk     = (blk_raw > 6'(LINE_BLOCKS)) ? 6'(LINE_BLOCKS) : blk_raw;
    blk16   = 16'(blk);
    rel_grp = lo - idr_pkg::BASE_GRP;
    rel_sen = lo - idr_pkg::BASE_SEN;
    rel_cen = lo - idr_pkg::BASE_CEN;
    rel_pri = lo - idr_pkg::BASE_PRI;
    rel_trg = lo - idr_pkg::BASE_TRG;
    rel_rte = lo - idr_pkg::BASE_RTE;
    hit_grp = (lo >= idr_pkg::BASE_GRP) && (rel_grp < (blk16 << 2));
    hit_sen = (lo >= idr_pkg::BASE_SEN) && (rel_sen < (blk16 << 2));
    hit_cen = (lo >= idr_pkg::BASE_CEN) && (rel_cen < (blk16 << 2));
    hit_pri = (lo >= idr_pkg::BASE_PRI) && (rel_pri < (blk16 << 5));
    hit_trg = (lo >= idr_pkg::BASE_TRG) && (rel_trg < (blk16 << 3));
    hit_rte = (lo >= idr_pkg::BASE_RTE) && (rel_rte < ((blk16 << 8) - 16'd8));

    dec_nxt.kind   = idr_pkg::K_NONE;
    dec_nxt.status = idr_pkg::ST_UNKNOWN;
    dec_nxt.wop    = idr_pkg::OP_STORE;
    dec_nxt.wr     = in_r.mode;
    dec_wa_nxt     = '0;
    dec_ra_nxt     = '0;

    if (!in_low) begin
      dec_nxt.status = idr_pkg::ST_UNKNOWN;
    end else if (lo == idr_pkg::OFF_CTL) begin
      dec_nxt.kind   = idr_pkg::K_CTL;
      dec_nxt.status = idr_pkg::ST_OK;
    end else if (lo == idr_pkg::OFF_TYPE) begin
      dec_nxt.kind   = idr_pkg::K_TYPE;
      dec_nxt.status = in_r.mode ? idr_pkg::ST_READONLY : idr_pkg::ST_OK;
    end else if (lo == idr_pkg::OFF_IDENT) begin
      dec_nxt.kind   = idr_pkg::K_IDENT;
      dec_nxt.status = in_r.mode ? idr_pkg::ST_READONLY : idr_pkg::ST_OK;
    end else if (lo == idr_pkg::OFF_ID2) begin
      dec_nxt.kind   = idr_pkg::K_ID2;
      dec_nxt.status = in_r.mode ? idr_pkg::ST_READONLY : idr_pkg::ST_OK;
    end else if (hit_grp) begin
      dec_nxt.kind   = idr_pkg::K_WORD;
      dec_nxt.status = (lo[1:0] != 2'd0) ? idr_pkg::ST_MISALIGN : idr_pkg::ST_OK;
      dec_wa_nxt     = WA_W'(GRP_OFS) + WA_W'(rel_grp[15:2]);
    end else if (hit_trg) begin
      dec_nxt.kind = idr_pkg::K_WORD;
      if (in_r.mode && (lo == idr_pkg::BASE_TRG)) begin
        dec_nxt.status = idr_pkg::ST_READONLY;
      end else begin
        dec_nxt.status = (lo[1:0] != 2'd0) ? idr_pkg::ST_MISALIGN : idr_pkg::ST_OK;
      end
      dec_wa_nxt = WA_W'(TRG_OFS) + WA_W'(rel_trg[15:2]);
    end else if (hit_pri) begin
      dec_nxt.kind   = idr_pkg::K_WORD;
      dec_nxt.status = (lo[1:0] != 2'd0) ? idr_pkg::ST_MISALIGN : idr_pkg::ST_OK;
      dec_wa_nxt     = WA_W'(PRI_OFS) + WA_W'(rel_pri[15:2]);
    end else if (hit_cen) begin
      dec_nxt.kind   = idr_pkg::K_WORD;
      dec_nxt.wop    = idr_pkg::OP_CLEAR;
      dec_nxt.status = (lo[1:0] != 2'd0) ? idr_pkg::ST_MISALIGN : idr_pkg::ST_OK;
      dec_wa_nxt     = WA_W'(ENA_OFS) + WA_W'(rel_cen[15:2]);
    end else if (hit_sen) begin
      dec_nxt.kind   = idr_pkg::K_WORD;
      dec_nxt.wop    = idr_pkg::OP_SET;
      dec_nxt.status = (lo[1:0] != 2'd0) ? idr_pkg::ST_MISALIGN : idr_pkg::ST_OK;
      dec_wa_nxt     = WA_W'(ENA_OFS) + WA_W'(rel_sen[15:2]);
    end else if (hit_rte) begin
      dec_nxt.kind   = idr_pkg::K_ROUTE;
      dec_nxt.status = (lo[2:0] != 3'd0) ? idr_pkg::ST_MISALIGN : idr_pkg::ST_OK;
      dec_ra_nxt     = RA_W'(rel_rte[15:3]);
    end
  end

  // modify and respond
  always_comb begin
    exe_wwe   = 1'b0;
    exe_rwe   = 1'b0;
    exe_wdata = in_r.write_data[31:0];
    exe_rd    = 64'd0;
    ctl_nxt   = ctl_r;
    if (dec_r.status == idr_pkg::ST_OK) begin
      unique case (dec_r.kind)
        idr_pkg::K_CTL: begin
          if (dec_r.wr) begin
            ctl_nxt = in_r.write_data[31:0] & ~idr_pkg::CTL_PENDING;
          end
          exe_rd = {32'd0, ctl_r};
        end
        idr_pkg::K_TYPE:  exe_rd = {32'd0, type_r};
        idr_pkg::K_IDENT: exe_rd = 64'd0;
        idr_pkg::K_ID2:   exe_rd = {32'd0, ident_r};
        idr_pkg::K_WORD: begin
          exe_wwe = dec_r.wr;
          case (dec_r.wop)
            idr_pkg::OP_SET:   exe_wdata = wram_q | in_r.write_data[31:0];
            idr_pkg::OP_CLEAR: exe_wdata = wram_q & ~in_r.write_data[31:0];
            default:           exe_wdata = in_r.write_data[31:0];
          endcase
          exe_rd = {32'd0, wram_q};
        end
        idr_pkg::K_ROUTE: begin
          exe_rwe = dec_r.wr;
          exe_rd  = rram_q;
        end
        default: exe_rd = 64'd0;
      endcase
    end
    if (dec_r.wr) begin
      exe_rd = 64'd0;
    end
    out_nxt.read_data       = exe_rd;
    out_nxt.access_status   = dec_r.status;
    out_nxt.needs_user_exit = 1'b0;
  end

  // memory ports
  always_comb begin
    wram_re    = (state_r == S_DEC);
    rram_re    = (state_r == S_DEC);
    if (state_r == S_CLR) begin
      wram_we    = (clr_cnt_r < RA_W'(WD));
      wram_waddr = WA_W'(clr_cnt_r);
      wram_wdata = 32'd0;
      rram_we    = 1'b1;
      rram_waddr = clr_cnt_r;
      rram_wdata = 64'd0;
    end else begin
      wram_we    = exe_done && exe_wwe;
      wram_waddr = dec_wa_r;
      wram_wdata = exe_wdata;
      rram_we    = exe_done && exe_rwe;
      rram_waddr = dec_ra_r;
      rram_wdata = in_r.write_data;
    end
  end

  idr_ram #(.WIDTH(32), .DEPTH(WD)) u_word_ram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .re    (wram_re),
    .raddr (dec_wa_nxt),
    .rdata (wram_q)
  );

  idr_ram #(.WIDTH(64), .DEPTH(RD)) u_route_ram (
    .clk   (clk),
    .we    (rram_we),
    .waddr (rram_waddr),
    .wdata (rram_wdata),
    .re    (rram_re),
    .raddr (dec_ra_nxt),
    .rdata (rram_q)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + RA_W'(1);
        if (clr_cnt_r == RA_W'(RD - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: state_nxt = S_EXE;
      S_EXE: begin
        if (exe_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_acc ? S_DEC : S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      base_r      <= 48'd0;
      type_r      <= idr_pkg::TYPE_RESET;
      ident_r     <= 32'd0;
      ctl_r       <= idr_pkg::CTL_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (exe_done) begin
        ctl_r <= ctl_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          idr_pkg::CFG_BASE:  base_r  <= cfg_data[47:0];
          idr_pkg::CFG_TYPE:  type_r  <= cfg_data[31:0];
          idr_pkg::CFG_IDENT: ident_r <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (state_r == S_DEC) begin
      dec_r    <= dec_nxt;
      dec_wa_r <= dec_wa_nxt;
      dec_ra_r <= dec_ra_nxt;
    end
    if (exe_done) begin
      out_r <= out_nxt;
    end
  end

  a_clear_blocks_requests: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("request taken during clearing pass");

  a_response_from_exe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXE))
    else $error("response loaded outside execute cycle");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.access_status != idr_pkg::ST_OK)) |-> (out_r.read_data == 64'd0))
    else $error("error response carries read data");

  a_dec_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_DEC))
    else $error("accepted request not decoded");

endmodule

### src/idr_ram.sv
module idr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
